### sv/fbsm_pkg.sv
`default_nettype none

package fbsm_pkg;

	// Field widths of the event and result words
	localparam int OPC_W      = 2;
	localparam int ID_W       = 8;
	localparam int FRAME_W    = 32;
	localparam int TICK_W     = 24;
	localparam int NCLI_W     = 5;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CLIENTS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd1;

	// Register values after reset
	localparam logic [NCLI_W-1:0] NUM_CLIENTS_RST  = 5'd2;
	localparam logic [TICK_W-1:0] FRAME_PERIOD_RST = 24'd33;

	typedef enum logic [OPC_W-1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_DONE  = 2'd2,
		OP_DISC  = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_GO         = 2'd0,
		KIND_RESET      = 2'd1,
		KIND_BAD_CLIENT = 2'd2
	} kind_t;

	// Settings seen by the barrier logic
	typedef struct packed {
		logic [ID_W-1:0]   eff_clients;
		logic [TICK_W-1:0] period;
	} cfg_t;

	// One result word, valid marks that the event produced one
	typedef struct packed {
		logic               valid;
		kind_t              kind;
		logic [FRAME_W-1:0] frame;
		logic [ID_W-1:0]    client_id;
	} res_t;

endpackage

`default_nettype wire

### sv/fbsm_cfg_regs.sv
`default_nettype none

module fbsm_cfg_regs #(
	parameter int MAX_CLIENTS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [fbsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fbsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output fbsm_pkg::cfg_t                        cfg
);
	import fbsm_pkg::*;

	logic [NCLI_W-1:0] num_clients_q;
	logic [TICK_W-1:0] period_q;
	logic [ID_W-1:0]   num_ext;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clients_q <= NUM_CLIENTS_RST;
			period_q      <= FRAME_PERIOD_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_NUM_CLIENTS) begin
				num_clients_q <= cfg_wdata[NCLI_W-1:0];
			end
			if (cfg_index == REG_FRAME_PERIOD) begin
				period_q <= cfg_wdata[TICK_W-1:0];
			end
		end
	end

	// Clamp the client count to 1..MAX_CLIENTS
	assign num_ext = ID_W'(num_clients_q);

	always_comb begin
		cfg.period = period_q;
		if (num_clients_q == '0) begin
			cfg.eff_clients = ID_W'(1);
		end else if (num_ext > ID_W'(MAX_CLIENTS)) begin
			cfg.eff_clients = ID_W'(MAX_CLIENTS);
		end else begin
			cfg.eff_clients = num_ext;
		end
	end

endmodule

`default_nettype wire

### sv/fbsm_barrier.sv
`default_nettype none

module fbsm_barrier #(
	parameter int MAX_CLIENTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step_en,
	input  fbsm_pkg::op_t                      op,
	input  wire logic [fbsm_pkg::ID_W-1:0]    client_id,
	input  wire logic [fbsm_pkg::FRAME_W-1:0] frame_number,
	input  fbsm_pkg::cfg_t                     cfg,
	output fbsm_pkg::res_t                     res
);
	import fbsm_pkg::*;

	logic [MAX_CLIENTS-1:0] started_q, started_d;
	logic [MAX_CLIENTS-1:0] ready_q, ready_d;
	logic                   all_conn_q, all_conn_d;
	logic                   pending_q, pending_d;
	logic [FRAME_W-1:0]     frame_q, frame_d;
	logic [TICK_W-1:0]      ticks_q, ticks_d;

	logic [MAX_CLIENTS-1:0] sel;
	logic [MAX_CLIENTS-1:0] mask;
	logic                   id_ok;
	logic                   skip_eval;
	logic [TICK_W-1:0]      ticks_inc;

	// Client decode and the mask of expected clients
	always_comb begin
		for (int i = 0; i < MAX_CLIENTS; i++) begin
			sel[i]  = (client_id == ID_W'(i));
			mask[i] = (ID_W'(i) < cfg.eff_clients);
		end
	end

	assign id_ok     = (client_id < cfg.eff_clients);
	assign ticks_inc = (ticks_q != '1) ? ticks_q + TICK_W'(1) : ticks_q;

	// Apply the event, then evaluate the barrier
	always_comb begin
		started_d  = started_q;
		ready_d    = ready_q;
		all_conn_d = all_conn_q;
		pending_d  = pending_q;
		frame_d    = frame_q;
		ticks_d    = ticks_q;
		skip_eval  = 1'b0;
		res        = '{valid: 1'b0, kind: KIND_GO, frame: '0, client_id: '0};

		unique case (op)
			OP_TICK: begin
				ticks_d = ticks_inc;
				if (pending_q && ticks_inc >= cfg.period) begin
					res.valid = 1'b1;
					res.kind  = KIND_GO;
					res.frame = frame_q;
					ready_d   = '0;
					pending_d = 1'b0;
					ticks_d   = '0;
					frame_d   = frame_q + FRAME_W'(1);
				end
			end
			OP_START: begin
				if (!id_ok) begin
					// start from a client beyond the expected set
					res.valid     = 1'b1;
					res.kind      = KIND_BAD_CLIENT;
					res.client_id = client_id;
					skip_eval     = 1'b1;
				end else begin
					// restart of a started client forces a frame reset once the frame number has left zero
					if (|(started_q & sel) && frame_q != '0) begin
						all_conn_d = 1'b0;
						frame_d    = '0;
						pending_d  = 1'b0;
						res.valid  = 1'b1;
						res.kind   = KIND_RESET;
					end
					started_d = started_q | sel;
				end
			end
			OP_DONE: begin
				if (all_conn_q && id_ok && frame_number == frame_q) begin
					ready_d = ready_q | sel;
				end
			end
			OP_DISC: begin
				if (id_ok && |(started_q & sel)) begin
					started_d = started_q & ~sel;
					if (all_conn_q) begin
						frame_d    = '0;
						pending_d  = 1'b0;
						all_conn_d = 1'b0;
						res.valid  = 1'b1;
						res.kind   = KIND_RESET;
					end
				end
			end
			default: begin
			end
		endcase

		if (!skip_eval) begin
			if (!all_conn_d) begin
				if ((started_d & mask) == mask) begin
					all_conn_d = 1'b1;
					pending_d  = 1'b1;
				end
			end else if ((ready_d & mask) == mask) begin
				pending_d = 1'b1;
			end
		end
	end

	// Barrier state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= '0;
			ready_q    <= '0;
			all_conn_q <= 1'b0;
			pending_q  <= 1'b0;
			frame_q    <= '0;
			ticks_q    <= '0;
		end else if (step_en) begin
			started_q  <= started_d;
			ready_q    <= ready_d;
			all_conn_q <= all_conn_d;
			pending_q  <= pending_d;
			frame_q    <= frame_d;
			ticks_q    <= ticks_d;
		end
	end

endmodule

`default_nettype wire

### sv/frame_barrier_sync_master_core.sv
`default_nettype none

// Frame-lock barrier master: takes tick, start, done and disconnect event
// words and returns at most one result word per event (go with frame number,
// reset notice, or out-of-range start error). One event is accepted every
// clock cycle while in_stall is low; each event passes an input register, the
// barrier logic that updates the per-client bits and counters, and a result
// register, which takes the result word once it is free. The barrier state
// update sets that rate. in_stall rises only while a result waits in the
// result register and the next event is held behind it.
// Config writes take effect at once and belong to idle periods.
module frame_barrier_sync_master_core #(
	parameter int MAX_CLIENTS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// event channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [fbsm_pkg::OPC_W-1:0]      opcode,
	input  wire logic [fbsm_pkg::ID_W-1:0]       client_id,
	input  wire logic [fbsm_pkg::FRAME_W-1:0]    frame_number,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [fbsm_pkg::KIND_W-1:0]          kind,
	output logic [fbsm_pkg::FRAME_W-1:0]         frame,
	output logic [fbsm_pkg::ID_W-1:0]            client_id_res,
	// config write port
	input  wire logic                             cfg_wr_en,
	input  wire logic [fbsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fbsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fbsm_pkg::*;

	logic               valid_s1;
	op_t                op_s1;
	logic [ID_W-1:0]    id_s1;
	logic [FRAME_W-1:0] fn_s1;

	logic               out_valid_q;
	kind_t              kind_q;
	logic [FRAME_W-1:0] frame_q;
	logic [ID_W-1:0]    id_res_q;

	logic               out_free;
	logic               step_en;
	cfg_t               cfg;
	res_t               res;

	fbsm_cfg_regs #(
		.MAX_CLIENTS(MAX_CLIENTS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	// Result register can take a word this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1 <= op_t'(opcode);
			id_s1 <= client_id;
			fn_s1 <= frame_number;
		end
	end

	fbsm_barrier #(
		.MAX_CLIENTS(MAX_CLIENTS)
	) u_barrier (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.op          (op_s1),
		.client_id   (id_s1),
		.frame_number(fn_s1),
		.cfg         (cfg),
		.res         (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= res.valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res.valid) begin
			kind_q   <= res.kind;
			frame_q  <= res.frame;
			id_res_q <= res.client_id;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign frame         = frame_q;
	assign client_id_res = id_res_q;

endmodule

`default_nettype wire

### sv/fbsm_checker.sv
`default_nettype none

module fbsm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [fbsm_pkg::KIND_W-1:0]  kind,
	input wire logic [fbsm_pkg::FRAME_W-1:0] frame,
	input wire logic [fbsm_pkg::ID_W-1:0]    client_id_res
);
	import fbsm_pkg::*;

	// A held result word keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(frame)
			&& $stable(client_id_res))
		else $error("result word changed while stalled");

	// Events are only held back behind a blocked result
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("event stall without a blocked result");

	// Only a go carries a frame number
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_GO |-> frame == '0)
		else $error("non-go result with a frame number");

	// Only an error result names a client
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_BAD_CLIENT |-> client_id_res == '0)
		else $error("client named in a non-error result");

endmodule

bind frame_barrier_sync_master_core fbsm_checker u_fbsm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.frame        (frame),
	.client_id_res(client_id_res)
);

`default_nettype wire
